### rtl/core/cdt_pkg.sv
// Shared types, constants and month-length and leap-year helpers for the date-time add/subtract block.
`default_nettype none
package cdt_pkg;

    localparam int YEAR_W   = 15;   // signed year port width
    localparam int MON_IN_W = 12;   // month amount width
    localparam int AMT_W    = 16;   // day/hour/minute/second amount width
    localparam int WORK_W   = 19;   // signed working width for second..day
    localparam int MV_W     = 14;   // signed working width for month
    localparam int LIN_W    = 17;   // signed linear year width
    localparam int DIV_W    = 17;   // divider dividend width
    localparam int DVR_W    = 9;    // divider divisor / remainder width

    localparam int YEAR_MAX = 9999;
    localparam int YEAR_MIN = -9999;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_ADD  = 2'd1,
        MODE_SUB  = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DSTART,
        S_DWAIT,
        S_CLAMP,
        S_WALK,
        S_FIN
    } state_t;

    typedef enum logic [2:0] {
        ST_SEC,
        ST_MIN,
        ST_HOUR,
        ST_MON,
        ST_LEAP,
        ST_LDLEAP
    } step_t;

    typedef struct packed {
        logic  capture;
        logic  div_start;
        logic  apply;
        step_t step;
        logic  clamp;
        logic  walk;
        logic  commit;
    } cdt_cmd_t;

    typedef struct packed {
        logic  div_done;
        mode_t mode;
        logic  walk_done;
        logic  walk_wrap;
    } cdt_stat_t;

    // Days in a month; leap selects 29 for February
    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        begin
            case (m)
                4'd2:                      d = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
                default:                   d = 5'd31;
            endcase
            return d;
        end
    endfunction

    // Leap year from the absolute year modulo 400
    function automatic logic leap_from_mod400(input logic [DVR_W-1:0] r);
        begin
            return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
        end
    endfunction

endpackage
`default_nettype wire

### rtl/core/cdt_div.sv
// Constant divider by 12, 24, 60 or 400 using reciprocal multiplication.
`default_nettype none
module cdt_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [cdt_pkg::DIV_W-1:0] dividend,
    input  wire logic [cdt_pkg::DVR_W-1:0] divisor,
    output logic [cdt_pkg::DIV_W-1:0]     quotient,
    output logic [cdt_pkg::DVR_W-1:0]     remainder,
    output logic                          done
);
    import cdt_pkg::*;

    localparam int RCP_W  = 16;
    localparam int PROD_W = DIV_W + RCP_W;

    logic [DIV_W-1:0]       x_reg;
    logic [DVR_W-1:0]       dvr_reg;
    logic [4:0]             k_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic                   stage_reg;
    logic                   done_reg;
    logic [DIV_W-1:0]       quo_reg;
    logic [DVR_W-1:0]       rem_reg;
    logic [DIV_W-1:0]       x_sh;
    logic [RCP_W-1:0]       rcp;
    logic [4:0]             k_sel;
    logic [DIV_W-1:0]       q_calc;
    logic [DIV_W+DVR_W-1:0] qd;
    logic [DIV_W-1:0]       r_calc;

    // power-of-two prescale and reciprocal, exact over the full dividend range
    always_comb
    begin
        case (divisor)
            DVR_W'(12):
            begin
                x_sh  = dividend >> 2;
                rcp   = RCP_W'(43691);
                k_sel = 5'd17;
            end
            DVR_W'(24):
            begin
                x_sh  = dividend >> 3;
                rcp   = RCP_W'(43691);
                k_sel = 5'd17;
            end
            DVR_W'(400):
            begin
                x_sh  = dividend >> 4;
                rcp   = RCP_W'(5243);
                k_sel = 5'd17;
            end
            default:
            begin
                // divide by 60
                x_sh  = dividend >> 2;
                rcp   = RCP_W'(34953);
                k_sel = 5'd19;
            end
        endcase
    end

    // quotient from the product, remainder by back-multiplication
    always_comb
    begin
        q_calc = DIV_W'(prod_reg >> k_reg);
        qd     = {{DVR_W{1'b0}}, q_calc} * {{DIV_W{1'b0}}, dvr_reg};
        r_calc = x_reg - qd[DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= start;
            done_reg  <= stage_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= dividend;
            dvr_reg  <= divisor;
            k_reg    <= k_sel;
            prod_reg <= {{RCP_W{1'b0}}, x_sh} * {{DIV_W{1'b0}}, rcp};
        end
        if (stage_reg)
        begin
            quo_reg <= q_calc;
            rem_reg <= r_calc[DVR_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule
`default_nettype wire

### rtl/core/cdt_datapath.sv
// Datapath: working date-time registers, carry/borrow steps, month walk and commit.
`default_nettype none
module cdt_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cdt_pkg::cdt_cmd_t            cmd,
    output cdt_pkg::cdt_stat_t                stat,
    input  wire logic [1:0]                   mode,
    input  wire logic signed [cdt_pkg::YEAR_W-1:0] year_amount,
    input  wire logic [cdt_pkg::MON_IN_W-1:0] month_amount,
    input  wire logic [cdt_pkg::AMT_W-1:0]    day_amount,
    input  wire logic [cdt_pkg::AMT_W-1:0]    hour_amount,
    input  wire logic [cdt_pkg::AMT_W-1:0]    minute_amount,
    input  wire logic [cdt_pkg::AMT_W-1:0]    second_amount,
    output logic signed [cdt_pkg::YEAR_W-1:0] out_year,
    output logic [3:0]                        out_month,
    output logic [4:0]                        out_day,
    output logic [4:0]                        out_hour,
    output logic [5:0]                        out_minute,
    output logic [5:0]                        out_second,
    output logic                              before_era,
    output logic                              error,
    output logic                              done
);
    import cdt_pkg::*;

    // held date-time
    logic signed [YEAR_W-1:0] cur_year_reg;
    logic [3:0]               cur_month_reg;
    logic [4:0]               cur_day_reg;
    logic [4:0]               cur_hour_reg;
    logic [5:0]               cur_minute_reg;
    logic [5:0]               cur_second_reg;
    logic                     err_reg;
    logic                     done_reg;

    // captured item
    mode_t                    mode_reg;
    logic signed [YEAR_W-1:0] ya_reg;
    logic [MON_IN_W-1:0]      ma_reg;
    logic [AMT_W-1:0]         da_reg;
    logic [AMT_W-1:0]         ha_reg;
    logic [AMT_W-1:0]         mia_reg;
    logic [AMT_W-1:0]         sa_reg;

    // working values
    logic signed [WORK_W-1:0] s_reg;
    logic signed [WORK_W-1:0] mi_reg;
    logic signed [WORK_W-1:0] h_reg;
    logic signed [WORK_W-1:0] d_reg;
    logic signed [MV_W-1:0]   m_reg;
    logic signed [LIN_W-1:0]  l_reg;
    logic                     leap_reg;

    // capture helpers
    logic signed [LIN_W-1:0]  lin_cur;
    logic signed [LIN_W-1:0]  n_years;
    logic signed [WORK_W-1:0] sa_x, mia_x, ha_x, da_x;
    logic signed [WORK_W-1:0] cs_x, cmi_x, ch_x, cd_x;
    logic signed [MV_W-1:0]   ma_x, cm_x;

    // divider hookup
    logic signed [WORK_W-1:0] v;
    logic                     v_neg;
    logic [WORK_W-1:0]        v_mag;
    logic [DIV_W-1:0]         dividend;
    logic [DVR_W-1:0]         divisor;
    logic [DIV_W-1:0]         quo;
    logic [DVR_W-1:0]         rem;
    logic                     div_done;
    logic signed [LIN_W-1:0]  abs_l;
    logic [YEAR_W:0]          abs_ya;

    // carry step results
    logic signed [WORK_W-1:0] lo_val;
    logic signed [WORK_W-1:0] hi_delta;

    // walk helpers
    logic [4:0]               dim_cur;
    logic [4:0]               dim_prev;
    logic                     walk_done;
    logic                     walk_wrap;

    // load check
    logic                     load_ok;

    cdt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dividend),
        .divisor   (divisor),
        .quotient  (quo),
        .remainder (rem),
        .done      (div_done)
    );

    // operands for capture
    always_comb
    begin
        lin_cur = (cur_year_reg > 0) ? LIN_W'(cur_year_reg) : LIN_W'(cur_year_reg) + LIN_W'(1);
        n_years = year_amount[YEAR_W-1] ? '0 : LIN_W'(year_amount);
        sa_x    = $signed({{(WORK_W-AMT_W){1'b0}}, second_amount});
        mia_x   = $signed({{(WORK_W-AMT_W){1'b0}}, minute_amount});
        ha_x    = $signed({{(WORK_W-AMT_W){1'b0}}, hour_amount});
        da_x    = $signed({{(WORK_W-AMT_W){1'b0}}, day_amount});
        cs_x    = $signed({{(WORK_W-6){1'b0}}, cur_second_reg});
        cmi_x   = $signed({{(WORK_W-6){1'b0}}, cur_minute_reg});
        ch_x    = $signed({{(WORK_W-5){1'b0}}, cur_hour_reg});
        cd_x    = $signed({{(WORK_W-5){1'b0}}, cur_day_reg});
        ma_x    = $signed({{(MV_W-MON_IN_W){1'b0}}, month_amount});
        cm_x    = $signed({{(MV_W-4){1'b0}}, cur_month_reg});
    end

    // divider operand select by step
    always_comb
    begin
        abs_l  = (l_reg > 0) ? l_reg : (LIN_W'(1) - l_reg);
        abs_ya = ya_reg[YEAR_W-1] ? (YEAR_W+1)'(-$signed({ya_reg[YEAR_W-1], ya_reg}))
                                  : {1'b0, ya_reg};
        v       = '0;
        divisor = DVR_W'(60);
        case (cmd.step)
            ST_SEC:    v = s_reg;
            ST_MIN:    v = mi_reg;
            ST_HOUR:
            begin
                v       = h_reg;
                divisor = DVR_W'(24);
            end
            ST_MON:
            begin
                v       = WORK_W'(m_reg);
                divisor = DVR_W'(12);
            end
            ST_LEAP:   divisor = DVR_W'(400);
            ST_LDLEAP: divisor = DVR_W'(400);
            default:   v = '0;
        endcase
        v_neg = v[WORK_W-1];
        v_mag = v_neg ? WORK_W'(-v) : WORK_W'(v);
        case (cmd.step)
            ST_LEAP:   dividend = DIV_W'(abs_l);
            ST_LDLEAP: dividend = DIV_W'(abs_ya);
            default:   dividend = v_mag[DIV_W-1:0];
        endcase
    end

    // floor carry: low digit and amount passed to the next field
    always_comb
    begin
        if (!v_neg)
        begin
            lo_val   = $signed({{(WORK_W-DVR_W){1'b0}}, rem});
            hi_delta = $signed({{(WORK_W-DIV_W){1'b0}}, quo});
        end
        else if (rem == '0)
        begin
            lo_val   = '0;
            hi_delta = -$signed({{(WORK_W-DIV_W){1'b0}}, quo});
        end
        else
        begin
            lo_val   = $signed({{(WORK_W-DVR_W){1'b0}}, divisor - rem});
            hi_delta = -($signed({{(WORK_W-DIV_W){1'b0}}, quo}) + WORK_W'(1));
        end
    end

    // month walk decisions
    always_comb
    begin
        dim_cur  = days_in(m_reg[3:0], leap_reg);
        dim_prev = days_in(m_reg[3:0] - 4'd1, leap_reg);
        if (mode_reg == MODE_ADD)
        begin
            walk_done = d_reg <= $signed({{(WORK_W-5){1'b0}}, dim_cur});
            walk_wrap = m_reg == MV_W'(12);
        end
        else
        begin
            walk_done = d_reg >= 1;
            walk_wrap = m_reg == MV_W'(1);
        end
    end

    // load field check
    always_comb
    begin
        load_ok = (ya_reg != '0) && (ya_reg >= YEAR_W'(YEAR_MIN)) && (ya_reg <= YEAR_W'(YEAR_MAX))
                  && (ma_reg >= MON_IN_W'(1)) && (ma_reg <= MON_IN_W'(12))
                  && (da_reg >= AMT_W'(1)) && (ha_reg < AMT_W'(24))
                  && (mia_reg < AMT_W'(60)) && (sa_reg < AMT_W'(60));
        if (load_ok && (da_reg > {11'd0, days_in(ma_reg[3:0], leap_reg)}))
            load_ok = 1'b0;
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode_t'(mode);
            ya_reg   <= year_amount;
            ma_reg   <= month_amount;
            da_reg   <= day_amount;
            ha_reg   <= hour_amount;
            mia_reg  <= minute_amount;
            sa_reg   <= second_amount;
            if (mode_t'(mode) == MODE_SUB)
            begin
                l_reg  <= lin_cur - n_years;
                m_reg  <= cm_x - ma_x - MV_W'(1);
                d_reg  <= cd_x - da_x;
                h_reg  <= ch_x - ha_x;
                mi_reg <= cmi_x - mia_x;
                s_reg  <= cs_x - sa_x;
            end
            else
            begin
                l_reg  <= lin_cur + n_years;
                m_reg  <= cm_x + ma_x - MV_W'(1);
                d_reg  <= cd_x + da_x;
                h_reg  <= ch_x + ha_x;
                mi_reg <= cmi_x + mia_x;
                s_reg  <= cs_x + sa_x;
            end
        end
        else if (cmd.apply && div_done)
        begin
            case (cmd.step)
                ST_SEC:
                begin
                    s_reg  <= lo_val;
                    mi_reg <= mi_reg + hi_delta;
                end
                ST_MIN:
                begin
                    mi_reg <= lo_val;
                    h_reg  <= h_reg + hi_delta;
                end
                ST_HOUR:
                begin
                    h_reg <= lo_val;
                    d_reg <= d_reg + hi_delta;
                end
                ST_MON:
                begin
                    m_reg <= MV_W'(lo_val) + MV_W'(1);
                    l_reg <= l_reg + LIN_W'(hi_delta);
                end
                ST_LEAP:   leap_reg <= leap_from_mod400(rem);
                ST_LDLEAP: leap_reg <= leap_from_mod400(rem);
                default:   leap_reg <= leap_reg;
            endcase
        end
        else if (cmd.clamp)
        begin
            if (d_reg > $signed({{(WORK_W-5){1'b0}}, dim_cur}))
                d_reg <= $signed({{(WORK_W-5){1'b0}}, dim_cur});
        end
        else if (cmd.walk && !walk_done)
        begin
            if (mode_reg == MODE_ADD)
            begin
                d_reg <= d_reg - $signed({{(WORK_W-5){1'b0}}, dim_cur});
                if (walk_wrap)
                begin
                    m_reg <= MV_W'(1);
                    l_reg <= l_reg + LIN_W'(1);
                end
                else
                    m_reg <= m_reg + MV_W'(1);
            end
            else
            begin
                if (walk_wrap)
                begin
                    // December has 31 days in every year
                    m_reg <= MV_W'(12);
                    l_reg <= l_reg - LIN_W'(1);
                    d_reg <= d_reg + WORK_W'(31);
                end
                else
                begin
                    m_reg <= m_reg - MV_W'(1);
                    d_reg <= d_reg + $signed({{(WORK_W-5){1'b0}}, dim_prev});
                end
            end
        end
    end

    // held date-time, error and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_year_reg   <= YEAR_W'(1960);
            cur_month_reg  <= 4'd1;
            cur_day_reg    <= 5'd1;
            cur_hour_reg   <= 5'd0;
            cur_minute_reg <= 6'd0;
            cur_second_reg <= 6'd0;
            err_reg        <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit;
            if (cmd.commit)
            begin
                case (mode_reg)
                    MODE_LOAD:
                    begin
                        err_reg <= !load_ok;
                        if (load_ok)
                        begin
                            cur_year_reg   <= ya_reg;
                            cur_month_reg  <= ma_reg[3:0];
                            cur_day_reg    <= da_reg[4:0];
                            cur_hour_reg   <= ha_reg[4:0];
                            cur_minute_reg <= mia_reg[5:0];
                            cur_second_reg <= sa_reg[5:0];
                        end
                    end
                    MODE_ADD, MODE_SUB:
                    begin
                        if (l_reg > LIN_W'(YEAR_MAX))
                        begin
                            // saturate at the top of the range
                            cur_year_reg   <= YEAR_W'(YEAR_MAX);
                            cur_month_reg  <= 4'd12;
                            cur_day_reg    <= 5'd31;
                            cur_hour_reg   <= 5'd23;
                            cur_minute_reg <= 6'd59;
                            cur_second_reg <= 6'd59;
                            err_reg        <= 1'b1;
                        end
                        else if (l_reg < LIN_W'(YEAR_MIN + 1))
                        begin
                            // saturate at the bottom of the range
                            cur_year_reg   <= YEAR_W'(YEAR_MIN);
                            cur_month_reg  <= 4'd1;
                            cur_day_reg    <= 5'd1;
                            cur_hour_reg   <= 5'd0;
                            cur_minute_reg <= 6'd0;
                            cur_second_reg <= 6'd0;
                            err_reg        <= 1'b1;
                        end
                        else
                        begin
                            cur_year_reg   <= (l_reg > 0) ? YEAR_W'(l_reg)
                                                          : YEAR_W'(l_reg - LIN_W'(1));
                            cur_month_reg  <= m_reg[3:0];
                            cur_day_reg    <= d_reg[4:0];
                            cur_hour_reg   <= h_reg[4:0];
                            cur_minute_reg <= mi_reg[5:0];
                            cur_second_reg <= s_reg[5:0];
                            err_reg        <= 1'b0;
                        end
                    end
                    default: err_reg <= 1'b0;
                endcase
            end
        end
    end

    always_comb
    begin
        stat.div_done  = div_done;
        stat.mode      = mode_reg;
        stat.walk_done = walk_done;
        stat.walk_wrap = walk_wrap;
    end

    assign out_year   = cur_year_reg;
    assign out_month  = cur_month_reg;
    assign out_day    = cur_day_reg;
    assign out_hour   = cur_hour_reg;
    assign out_minute = cur_minute_reg;
    assign out_second = cur_second_reg;
    assign before_era = cur_year_reg[YEAR_W-1];
    assign error      = err_reg;
    assign done       = done_reg;

endmodule
`default_nettype wire

### rtl/core/cdt_ctrl.sv
// Controller: sequences capture, carry steps, leap lookups, day clamp, month walk and commit.
`default_nettype none
module cdt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         mode,
    input  wire cdt_pkg::cdt_stat_t stat,
    output cdt_pkg::cdt_cmd_t       cmd,
    output logic                    busy
);
    import cdt_pkg::*;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   first_reg, first_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        first_next = first_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    first_next = 1'b1;
                    case (mode_t'(mode))
                        MODE_LOAD:
                        begin
                            step_next  = ST_LDLEAP;
                            state_next = S_DSTART;
                        end
                        MODE_ADD, MODE_SUB:
                        begin
                            step_next  = ST_SEC;
                            state_next = S_DSTART;
                        end
                        default: state_next = S_FIN;
                    endcase
                end
            end
            S_DSTART: state_next = S_DWAIT;
            S_DWAIT:
            begin
                if (stat.div_done)
                begin
                    case (step_reg)
                        ST_SEC:
                        begin
                            step_next  = ST_MIN;
                            state_next = S_DSTART;
                        end
                        ST_MIN:
                        begin
                            step_next  = ST_HOUR;
                            state_next = S_DSTART;
                        end
                        ST_HOUR:
                        begin
                            step_next  = ST_MON;
                            state_next = S_DSTART;
                        end
                        ST_MON:
                        begin
                            step_next  = ST_LEAP;
                            state_next = S_DSTART;
                        end
                        ST_LEAP:
                        begin
                            first_next = 1'b0;
                            state_next = (first_reg && stat.mode == MODE_SUB) ? S_CLAMP : S_WALK;
                        end
                        default: state_next = S_FIN;
                    endcase
                end
            end
            S_CLAMP: state_next = S_WALK;
            S_WALK:
            begin
                if (stat.walk_done)
                    state_next = S_FIN;
                else if (stat.walk_wrap)
                begin
                    step_next  = ST_LEAP;
                    state_next = S_DSTART;
                end
            end
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.capture   = (state_reg == S_IDLE) && start;
        cmd.div_start = state_reg == S_DSTART;
        cmd.apply     = state_reg == S_DWAIT;
        cmd.step      = step_reg;
        cmd.clamp     = state_reg == S_CLAMP;
        cmd.walk      = state_reg == S_WALK;
        cmd.commit    = state_reg == S_FIN;
        busy          = state_reg != S_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= ST_SEC;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            first_reg <= first_next;
        end
    end

endmodule
`default_nettype wire

### rtl/core/calendar_datetime_add_subtract.sv
// Top level of the Gregorian date-time register with load, add and subtract.
// An item is taken when start is high and busy is low; its one result shows on the
// out_* ports, before_era and error with done high for exactly one cycle, the first
// cycle with busy low again, and the receiver cannot stall it. The outputs keep the
// held date-time between results. After acceptance busy stays high while a load runs
// one constant divide for the leap year and then the commit; the unused mode 3 goes
// straight to the commit. An add runs five constant divides for the second, minute,
// hour and month carries and the first leap lookup, then one walk check and the
// commit; a subtract adds a day clamp before the walk. Each month walked by the day
// carry adds one walk step, and each year boundary that the walk crosses adds a new
// leap lookup.
`default_nettype none
module calendar_datetime_add_subtract (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   mode,
    input  wire logic signed [cdt_pkg::YEAR_W-1:0] year_amount,
    input  wire logic [cdt_pkg::MON_IN_W-1:0] month_amount,
    input  wire logic [cdt_pkg::AMT_W-1:0]    day_amount,
    input  wire logic [cdt_pkg::AMT_W-1:0]    hour_amount,
    input  wire logic [cdt_pkg::AMT_W-1:0]    minute_amount,
    input  wire logic [cdt_pkg::AMT_W-1:0]    second_amount,
    output logic                              done,
    output logic signed [cdt_pkg::YEAR_W-1:0] out_year,
    output logic [3:0]                        out_month,
    output logic [4:0]                        out_day,
    output logic [4:0]                        out_hour,
    output logic [5:0]                        out_minute,
    output logic [5:0]                        out_second,
    output logic                              before_era,
    output logic                              error
);
    import cdt_pkg::*;

    cdt_cmd_t  cmd;
    cdt_stat_t stat;

    cdt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    cdt_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .mode          (mode),
        .year_amount   (year_amount),
        .month_amount  (month_amount),
        .day_amount    (day_amount),
        .hour_amount   (hour_amount),
        .minute_amount (minute_amount),
        .second_amount (second_amount),
        .out_year      (out_year),
        .out_month     (out_month),
        .out_day       (out_day),
        .out_hour      (out_hour),
        .out_minute    (out_minute),
        .out_second    (out_second),
        .before_era    (before_era),
        .error         (error),
        .done          (done)
    );

endmodule
`default_nettype wire
